FILE: rtl/bfbs_pkg.sv
// bfbs_pkg: shared constants and types for the beast frame byte stuffer
// no dependencies; used by bfbs_field_unit and the top level
`timescale 1ns / 1ps

package bfbs_pkg;

	localparam logic [7:0] FRAME_MARK = 8'h1A;
	localparam logic [7:0] TYPE_SHORT = 8'h32;
	localparam logic [7:0] TYPE_LONG  = 8'h33;
	localparam logic [3:0] SHORT_BYTES = 4'd7;
	localparam logic [3:0] LONG_BYTES  = 4'd14;
	localparam logic [7:0] LEVEL_MAX   = 8'd255;

	// timestamp, level and up to fourteen message bytes
	localparam int HDR_FIELDS = 7;
	localparam int FIELD_BYTES = HDR_FIELDS + 14;
	localparam int FIELD_W = FIELD_BYTES * 8;
	localparam int CNT_W = $clog2(FIELD_BYTES + 1);

	typedef struct packed {
		logic               load;
		logic [FIELD_W-1:0] data;
		logic [CNT_W-1:0]   count;
		logic               shift;
	} unit_ctrl_t;

	typedef struct packed {
		logic [7:0]       top_byte;
		logic             is_mark;
		logic             last_field;
		logic [CNT_W-1:0] count;
	} unit_stat_t;

endpackage

FILE: rtl/beast_frame_byte_stuffer_top.sv
// beast_frame_byte_stuffer_top: sequencer and output register for beast frames
// depends on bfbs_pkg and bfbs_field_unit
// a taken request enters S_MARK, which loads the marker into the output register; then one byte
// per cycle while out_stall allows. A frame of 2 header bytes plus 14 or 21 field bytes, each
// 0x1a doubled, is 16 to 44 bytes; in_stall stays high until the last byte is registered
// reset: feed_q clears to 0, sequencer idle, output register empty
`timescale 1ns / 1ps

module beast_frame_byte_stuffer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [6:0]  msg_bits,
	input  logic [63:0] msg_head,
	input  logic [47:0] msg_tail,
	input  logic [47:0] timestamp,
	input  logic signed [15:0] rx_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_last
);

	typedef enum logic [2:0] {S_IDLE, S_MARK, S_TYPE, S_FIELD, S_DUP} state_t;

	state_t state_q, state_d;
	logic   feed_q;
	logic   long_q;
	logic   out_valid_q;
	logic [7:0] out_byte_q;
	logic   frame_last_q;

	bfbs_pkg::unit_ctrl_t ctrl;
	bfbs_pkg::unit_stat_t stat;

	logic [3:0] nbytes;
	logic       len_ok;
	logic [7:0] sig;
	logic       accept;
	logic       start;
	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_last;
	logic       shift;

	assign nbytes = msg_bits[6:3];
	assign len_ok = (nbytes == bfbs_pkg::SHORT_BYTES) || (nbytes == bfbs_pkg::LONG_BYTES);

	// clamp to 0..255
	always_comb begin
		if (rx_level[15]) begin
			sig = 8'h00;
		end else if (|rx_level[14:8]) begin
			sig = bfbs_pkg::LEVEL_MAX;
		end else begin
			sig = rx_level[7:0];
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign start    = accept && feed_q && len_ok;
	assign emit     = (state_q != S_IDLE) && (!out_valid_q || !out_stall);

	assign ctrl.load  = start;
	assign ctrl.data  = {timestamp, sig, msg_head, msg_tail};
	assign ctrl.count = bfbs_pkg::CNT_W'(nbytes) + bfbs_pkg::CNT_W'(bfbs_pkg::HDR_FIELDS);
	assign ctrl.shift = shift;

	always_comb begin
		state_d    = state_q;
		emit_byte  = stat.top_byte;
		emit_last  = 1'b0;
		shift      = 1'b0;
		case (state_q)
			S_MARK: begin
				emit_byte = bfbs_pkg::FRAME_MARK;
				if (emit) state_d = S_TYPE;
			end
			S_TYPE: begin
				emit_byte = long_q ? bfbs_pkg::TYPE_LONG : bfbs_pkg::TYPE_SHORT;
				if (emit) state_d = S_FIELD;
			end
			S_FIELD: begin
				emit_last = stat.last_field && !stat.is_mark;
				if (emit) begin
					if (stat.is_mark) begin
						state_d = S_DUP;
					end else begin
						shift = 1'b1;
						if (stat.last_field) state_d = S_IDLE;
					end
				end
			end
			S_DUP: begin
				// second copy of a stuffed marker byte
				emit_last = stat.last_field;
				if (emit) begin
					shift = 1'b1;
					state_d = stat.last_field ? S_IDLE : S_FIELD;
				end
			end
			default: begin
				if (start) state_d = S_MARK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			feed_q       <= 1'b0;
			long_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= 8'h00;
			frame_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) feed_q <= cfg_wdata;
			if (start) long_q <= (nbytes == bfbs_pkg::LONG_BYTES);
			if (emit) begin
				out_valid_q  <= 1'b1;
				out_byte_q   <= emit_byte;
				frame_last_q <= emit_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	bfbs_field_unit u_field (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign frame_last = frame_last_q;

	// a good request starts a frame with the marker
	a_start_mark: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == S_MARK)
		else $error("frame did not start with marker");

	// the duplicate state only follows a marker byte in the field register
	a_dup_mark: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUP |-> stat.is_mark)
		else $error("duplicate byte is not a marker");

	// field bytes remain while sending fields
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIELD || state_q == S_DUP) |-> stat.count != '0)
		else $error("field count ran out mid frame");

	// the last byte of a frame returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == S_IDLE && frame_last)
		else $error("last byte did not end the frame");

endmodule

FILE: rtl/bfbs_field_unit.sv
// bfbs_field_unit: field byte shift register with the shared marker compare
// depends on bfbs_pkg
`timescale 1ns / 1ps

module bfbs_field_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  bfbs_pkg::unit_ctrl_t ctrl,
	output bfbs_pkg::unit_stat_t stat
);

	logic [bfbs_pkg::FIELD_W-1:0] data_q;
	logic [bfbs_pkg::CNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.load) begin
			count_q <= ctrl.count;
		end else if (ctrl.shift && count_q != '0) begin
			count_q <= count_q - bfbs_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= ctrl.data;
		end else if (ctrl.shift) begin
			data_q <= {data_q[bfbs_pkg::FIELD_W-9:0], 8'h00};
		end
	end

	assign stat.top_byte   = data_q[bfbs_pkg::FIELD_W-1 -: 8];
	assign stat.is_mark    = (data_q[bfbs_pkg::FIELD_W-1 -: 8] == bfbs_pkg::FRAME_MARK);
	assign stat.last_field = (count_q == bfbs_pkg::CNT_W'(1));
	assign stat.count      = count_q;

endmodule
